/* rtl/hurl_pkg.sv */
`default_nettype none

package hurl_pkg;

  localparam int unsigned OFFS_W = 11;
  localparam int unsigned CNT_W  = OFFS_W + 1;

  localparam logic [1:0] CFG_PAYLOAD_OFFSET   = 2'd0;
  localparam logic [1:0] CFG_MIN_FRAME_LENGTH = 2'd1;
  localparam logic [1:0] CFG_URL_LIMIT        = 2'd2;

  localparam logic [7:0]  PAYLOAD_OFFSET_RST   = 8'd56;
  localparam logic [7:0]  MIN_FRAME_LENGTH_RST = 8'd54;
  localparam logic [11:0] URL_LIMIT_RST        = 12'd1024;

  localparam logic [7:0] ETH_TYPE_HI = 8'h08;
  localparam logic [7:0] ETH_TYPE_LO = 8'h00;
  localparam logic [7:0] IP_PROTO_TCP = 8'h06;
  localparam logic [OFFS_W-1:0] ETH_TYPE_HI_OFFS = 11'd14;
  localparam logic [OFFS_W-1:0] ETH_TYPE_LO_OFFS = 11'd15;
  localparam logic [OFFS_W-1:0] IP_PROTO_OFFS    = 11'd25;

  localparam logic [23:0] PAT_GET  = 24'h474554;
  localparam logic [31:0] PAT_POST = 32'h504F5354;
  localparam logic [15:0] PAT_CRLF = 16'h0D0A;
  localparam logic [31:0] PAT_CRLFCRLF = 32'h0D0A0D0A;
  localparam logic [7:0]  CHAR_H = 8'h48;
  localparam logic [2:0]  HOST_PAT_LEN = 3'd5;

  localparam logic [12:0] URL_PREFIX_LEN = 13'd7;
  localparam logic [OFFS_W-1:0] VERSION_SUFFIX_LEN = 11'd9;

  typedef enum logic [1:0] {
    METH_NONE = 2'd0,
    METH_GET  = 2'd1,
    METH_POST = 2'd2
  } method_t;

  typedef enum logic [1:0] {
    ST_NOT_TCP  = 2'd0,
    ST_NOT_HTTP = 2'd1,
    ST_NO_HOST  = 2'd2,
    ST_URL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0]  byte_count;
    logic              eth_hi;
    logic              eth_lo;
    logic              proto;
    logic              host_end_found;
    logic              uri_end_found;
    logic              hdr_end_found;
    method_t           method;
    logic [OFFS_W-1:0] host_start;
    logic [OFFS_W-1:0] host_end;
    logic [OFFS_W-1:0] host_len;
    logic [OFFS_W-1:0] uri_line_end;
    logic [OFFS_W-1:0] uri_len;
    logic [OFFS_W-1:0] header_end;
  } summary_t;

  typedef struct packed {
    status_t           status;
    method_t           method;
    logic [OFFS_W-1:0] host_offset;
    logic [OFFS_W-1:0] host_length;
    logic [OFFS_W-1:0] uri_offset;
    logic [OFFS_W-1:0] uri_length;
    logic              uri_dropped;
    logic [11:0]       url_length;
  } result_t;

  function automatic logic [7:0] host_pat_byte(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h48;
      3'd1:    ch = 8'h6F;
      3'd2:    ch = 8'h73;
      3'd3:    ch = 8'h74;
      3'd4:    ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [OFFS_W-1:0] uri_start(input logic [7:0] payload_offset,
                                                  input method_t method);
    logic [OFFS_W-1:0] base;
    base = {3'b000, payload_offset};
    return (method == METH_GET) ? base + 11'd4 : base + 11'd5;
  endfunction

endpackage

`default_nettype wire

/* rtl/hurl_tracker.sv */
`default_nettype none

module hurl_tracker (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 last_byte,
  input  wire logic [7:0]           payload_offset,
  input  wire logic                 snap_take,
  output logic                      snap_valid,
  output hurl_pkg::summary_t        snap
);

  logic [hurl_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]                 recent_r, recent_nxt;
  logic                        eth_hi_r, eth_hi_nxt;
  logic                        eth_lo_r, eth_lo_nxt;
  logic                        proto_r, proto_nxt;
  logic                        host_f_r, host_f_nxt;
  logic                        host_end_f_r, host_end_f_nxt;
  logic                        uri_end_f_r, uri_end_f_nxt;
  logic                        hdr_f_r, hdr_f_nxt;
  hurl_pkg::method_t           method_r, method_nxt;
  logic [2:0]                  match_r, match_nxt;
  logic [hurl_pkg::CNT_W-1:0]  host_start_r, host_start_nxt;
  logic [hurl_pkg::OFFS_W-1:0] host_end_r, host_end_nxt;
  logic [hurl_pkg::OFFS_W-1:0] host_len_r, host_len_nxt;
  logic [hurl_pkg::OFFS_W-1:0] uri_end_r, uri_end_nxt;
  logic [hurl_pkg::OFFS_W-1:0] uri_len_r, uri_len_nxt;
  logic [hurl_pkg::OFFS_W-1:0] hdr_end_r, hdr_end_nxt;
  logic                        snap_valid_r;
  hurl_pkg::summary_t          snap_r, snap_nxt;

  logic                        accept;
  logic                        take;
  logic [hurl_pkg::OFFS_W-1:0] o;
  logic [hurl_pkg::OFFS_W-1:0] p_ext;
  logic [hurl_pkg::OFFS_W-1:0] cr;
  logic [hurl_pkg::OFFS_W-1:0] ustart;
  logic                        crlf;

  assign in_ready   = !snap_valid_r || snap_take;
  assign accept     = in_valid && in_ready;
  assign take       = accept && !cnt_r[hurl_pkg::CNT_W-1];
  assign o          = cnt_r[hurl_pkg::OFFS_W-1:0];
  assign p_ext      = {3'b000, payload_offset};
  assign cr         = o - 11'd1;
  assign ustart     = hurl_pkg::uri_start(payload_offset, method_r);
  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

  always_comb begin
    cnt_nxt        = cnt_r;
    recent_nxt     = recent_r;
    eth_hi_nxt     = eth_hi_r;
    eth_lo_nxt     = eth_lo_r;
    proto_nxt      = proto_r;
    host_f_nxt     = host_f_r;
    host_end_f_nxt = host_end_f_r;
    uri_end_f_nxt  = uri_end_f_r;
    hdr_f_nxt      = hdr_f_r;
    method_nxt     = method_r;
    match_nxt      = match_r;
    host_start_nxt = host_start_r;
    host_end_nxt   = host_end_r;
    host_len_nxt   = host_len_r;
    uri_end_nxt    = uri_end_r;
    uri_len_nxt    = uri_len_r;
    hdr_end_nxt    = hdr_end_r;
    crlf           = 1'b0;
    if (take) begin
      cnt_nxt    = cnt_r + 12'd1;
      recent_nxt = {recent_r[23:0], data_byte};
      if (o == hurl_pkg::ETH_TYPE_HI_OFFS && data_byte == hurl_pkg::ETH_TYPE_HI) begin
        eth_hi_nxt = 1'b1;
      end
      if (o == hurl_pkg::ETH_TYPE_LO_OFFS && data_byte == hurl_pkg::ETH_TYPE_LO) begin
        eth_lo_nxt = 1'b1;
      end
      if (o == hurl_pkg::IP_PROTO_OFFS && data_byte == hurl_pkg::IP_PROTO_TCP) begin
        proto_nxt = 1'b1;
      end
      if (o == p_ext + 11'd2 && recent_nxt[23:0] == hurl_pkg::PAT_GET) begin
        method_nxt = hurl_pkg::METH_GET;
      end
      if (o == p_ext + 11'd3 && method_r == hurl_pkg::METH_NONE &&
          recent_nxt == hurl_pkg::PAT_POST) begin
        method_nxt = hurl_pkg::METH_POST;
      end
      if (o >= p_ext && !host_f_r && !hdr_f_r) begin
        if (data_byte == hurl_pkg::host_pat_byte(match_r)) begin
          match_nxt = match_r + 3'd1;
        end else begin
          match_nxt = (data_byte == hurl_pkg::CHAR_H) ? 3'd1 : 3'd0;
        end
        if (match_nxt == hurl_pkg::HOST_PAT_LEN) begin
          host_f_nxt     = 1'b1;
          host_start_nxt = {1'b0, o} + 12'd2;
        end
      end
      crlf = (o != 11'd0) && (recent_nxt[15:0] == hurl_pkg::PAT_CRLF);
      if (crlf) begin
        if (host_f_r && !host_end_f_r && {1'b0, cr} >= host_start_r) begin
          host_end_f_nxt = 1'b1;
          host_end_nxt   = cr;
          host_len_nxt   = cr - host_start_r[hurl_pkg::OFFS_W-1:0];
        end
        if (method_nxt != hurl_pkg::METH_NONE && !uri_end_f_r && cr >= ustart) begin
          uri_end_f_nxt = 1'b1;
          uri_end_nxt   = cr;
          uri_len_nxt   = cr - ustart;
        end
      end
      if (o >= p_ext + 11'd3 && !hdr_f_r && recent_nxt == hurl_pkg::PAT_CRLFCRLF) begin
        hdr_f_nxt   = 1'b1;
        hdr_end_nxt = o - 11'd3;
      end
    end
  end

  always_comb begin
    snap_nxt.byte_count     = cnt_nxt;
    snap_nxt.eth_hi         = eth_hi_nxt;
    snap_nxt.eth_lo         = eth_lo_nxt;
    snap_nxt.proto          = proto_nxt;
    snap_nxt.host_end_found = host_end_f_nxt;
    snap_nxt.uri_end_found  = uri_end_f_nxt;
    snap_nxt.hdr_end_found  = hdr_f_nxt;
    snap_nxt.method         = method_nxt;
    snap_nxt.host_start     = host_start_nxt[hurl_pkg::OFFS_W-1:0];
    snap_nxt.host_end       = host_end_nxt;
    snap_nxt.host_len       = host_len_nxt;
    snap_nxt.uri_line_end   = uri_end_nxt;
    snap_nxt.uri_len        = uri_len_nxt;
    snap_nxt.header_end     = hdr_end_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      cnt_r        <= '0;
      recent_r     <= '0;
      eth_hi_r     <= 1'b0;
      eth_lo_r     <= 1'b0;
      proto_r      <= 1'b0;
      host_f_r     <= 1'b0;
      host_end_f_r <= 1'b0;
      uri_end_f_r  <= 1'b0;
      hdr_f_r      <= 1'b0;
      method_r     <= hurl_pkg::METH_NONE;
      match_r      <= '0;
      host_start_r <= '0;
      host_end_r   <= '0;
      host_len_r   <= '0;
      uri_end_r    <= '0;
      uri_len_r    <= '0;
      hdr_end_r    <= '0;
    end else begin
      cnt_r        <= cnt_nxt;
      recent_r     <= recent_nxt;
      eth_hi_r     <= eth_hi_nxt;
      eth_lo_r     <= eth_lo_nxt;
      proto_r      <= proto_nxt;
      host_f_r     <= host_f_nxt;
      host_end_f_r <= host_end_f_nxt;
      uri_end_f_r  <= uri_end_f_nxt;
      hdr_f_r      <= hdr_f_nxt;
      method_r     <= method_nxt;
      match_r      <= match_nxt;
      host_start_r <= host_start_nxt;
      host_end_r   <= host_end_nxt;
      host_len_r   <= host_len_nxt;
      uri_end_r    <= uri_end_nxt;
      uri_len_r    <= uri_len_nxt;
      hdr_end_r    <= hdr_end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (accept && last_byte) begin
      snap_valid_r <= 1'b1;
    end else if (snap_take) begin
      snap_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      snap_r <= snap_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/hurl_finish.sv */
`default_nettype none

module hurl_finish (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                snap_valid,
  input  hurl_pkg::summary_t       snap,
  output logic                     snap_take,
  input  wire logic [7:0]          payload_offset,
  input  wire logic [7:0]          min_frame_length,
  input  wire logic [11:0]         url_limit,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output hurl_pkg::result_t        result
);

  logic                        out_valid_r;
  hurl_pkg::result_t           result_r, result_nxt;

  logic                        tcp;
  logic                        host_ok;
  logic [12:0]                 host_url;
  logic [12:0]                 limit_ext;
  logic [hurl_pkg::OFFS_W-1:0] line;
  logic [12:0]                 sum;
  logic                        drop;
  logic [hurl_pkg::OFFS_W-1:0] ulen;

  assign snap_take = snap_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign result    = result_r;

  always_comb begin
    tcp = (snap.byte_count >= {4'b0000, min_frame_length}) &&
          snap.eth_hi && snap.eth_lo && snap.proto;
    limit_ext = {1'b0, url_limit};
    host_url  = {2'b00, snap.host_len} + hurl_pkg::URL_PREFIX_LEN;
    host_ok   = tcp && (snap.method != hurl_pkg::METH_NONE) && snap.hdr_end_found &&
                snap.host_end_found && (snap.host_end <= snap.header_end) &&
                (snap.host_len != '0) && (host_url <= limit_ext);
    line = (snap.uri_end_found && snap.uri_line_end <= snap.header_end) ?
           snap.uri_len : '0;
    sum  = {2'b00, snap.host_len} + {2'b00, line};
    drop = (line < hurl_pkg::VERSION_SUFFIX_LEN) || (sum > limit_ext + 13'd2);
    ulen = drop ? '0 : line - hurl_pkg::VERSION_SUFFIX_LEN;

    result_nxt = '0;
    if (tcp) begin
      result_nxt.method = snap.method;
      result_nxt.status = (snap.method == hurl_pkg::METH_NONE) ?
                          hurl_pkg::ST_NOT_HTTP : hurl_pkg::ST_NO_HOST;
    end else begin
      result_nxt.method = hurl_pkg::METH_NONE;
      result_nxt.status = hurl_pkg::ST_NOT_TCP;
    end
    if (host_ok) begin
      result_nxt.status      = hurl_pkg::ST_URL;
      result_nxt.host_offset = snap.host_start;
      result_nxt.host_length = snap.host_len;
      result_nxt.uri_offset  = hurl_pkg::uri_start(payload_offset, snap.method);
      result_nxt.uri_length  = ulen;
      result_nxt.uri_dropped = drop;
      result_nxt.url_length  = 12'(host_url + {2'b00, ulen});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (snap_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      result_r <= result_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/http_request_url_locator_top.sv */
// A frame's result is registered first in the frame summary register, then in the result register.
// Throughput: one byte per cycle unless stalled; the per-byte match update is a single stage.
// The frame summary register and the result register stall only when results are not taken.
// Reset (rst_n low, synchronous) clears the match state and both valid flags and loads the
// configuration registers with payload offset 56, minimum frame length 54 and URL limit 1024.
`default_nettype none

module http_request_url_locator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // method, host_offset, host_length, uri_offset,
                                       // uri_length, uri_dropped, url_length, zero fill
  output logic [1:0]       out_tuser,  // status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  logic [7:0]         payload_offset_r;
  logic [7:0]         min_frame_length_r;
  logic [11:0]        url_limit_r;
  logic               snap_valid;
  logic               snap_take;
  hurl_pkg::summary_t snap;
  hurl_pkg::result_t  result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_offset_r   <= hurl_pkg::PAYLOAD_OFFSET_RST;
      min_frame_length_r <= hurl_pkg::MIN_FRAME_LENGTH_RST;
      url_limit_r        <= hurl_pkg::URL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == hurl_pkg::CFG_PAYLOAD_OFFSET) begin
        payload_offset_r <= cfg_data[7:0];
      end
      if (cfg_index == hurl_pkg::CFG_MIN_FRAME_LENGTH) begin
        min_frame_length_r <= cfg_data[7:0];
      end
      if (cfg_index == hurl_pkg::CFG_URL_LIMIT) begin
        url_limit_r <= cfg_data;
      end
    end
  end

  hurl_tracker u_tracker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .data_byte      (in_tdata),
    .last_byte      (in_tlast),
    .payload_offset (payload_offset_r),
    .snap_take      (snap_take),
    .snap_valid     (snap_valid),
    .snap           (snap)
  );

  hurl_finish u_finish (
    .clk              (clk),
    .rst_n            (rst_n),
    .snap_valid       (snap_valid),
    .snap             (snap),
    .snap_take        (snap_take),
    .payload_offset   (payload_offset_r),
    .min_frame_length (min_frame_length_r),
    .url_limit        (url_limit_r),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .result           (result)
  );

  assign out_tuser = result.status;
  assign out_tdata = {5'b00000, result.url_length, result.uri_dropped, result.uri_length,
                      result.uri_offset, result.host_length, result.host_offset,
                      result.method};

endmodule

`default_nettype wire
